// ===== rtl/lgs_pkg.sv =====
// Shared constants and types for the life generation step block.
// Used by lgs_row_update and life_generation_step; depends on nothing else.
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    // board memory addressing: one word per row, one bit per column
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLS);
    // row counter and clamped dimensions, able to hold MAX_ROWS itself
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);

    // configuration registers
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    // input word fields
    localparam int ACT_W   = 2;
    localparam int FIELD_W = 6;
    localparam int IN_W    = 16;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // result word fields
    localparam int GEN_W = 16;
    localparam int OUT_W = 24;
    localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

    typedef logic [MAX_COLS-1:0] row_t;

endpackage

// ===== rtl/lgs_row_update.sv =====
// Life rule B3/S23 applied to one full board row from three neighbor rows.
// Depends on lgs_pkg (row_t, MAX_COLS).
`timescale 1ns / 1ps

module lgs_row_update
(
    input  lgs_pkg::row_t above,
    input  lgs_pkg::row_t center,
    input  lgs_pkg::row_t below,
    input  lgs_pkg::row_t col_mask,
    output lgs_pkg::row_t new_row,
    output logic          changed
);

    // padded by one dead column on each side, columns beyond the grid masked off
    logic [lgs_pkg::MAX_COLS+1:0] above_p;
    logic [lgs_pkg::MAX_COLS+1:0] center_p;
    logic [lgs_pkg::MAX_COLS+1:0] below_p;

    assign above_p  = {1'b0, above & col_mask, 1'b0};
    assign center_p = {1'b0, center & col_mask, 1'b0};
    assign below_p  = {1'b0, below & col_mask, 1'b0};

    always_comb
    begin
        logic [3:0] cnt;
        logic       nv;
        cnt = '0;
        nv  = 1'b0;
        for (int c = 0; c < lgs_pkg::MAX_COLS; c++)
        begin
            cnt = {3'b0, above_p[c]} + {3'b0, above_p[c+1]} + {3'b0, above_p[c+2]}
                + {3'b0, center_p[c]} + {3'b0, center_p[c+2]}
                + {3'b0, below_p[c]} + {3'b0, below_p[c+1]} + {3'b0, below_p[c+2]};
            if (cnt == 4'd3)
                nv = 1'b1;
            else if (cnt == 4'd2)
                nv = center[c];
            else
                nv = 1'b0;
            // columns outside the grid in use keep their value
            new_row[c] = col_mask[c] ? nv : center[c];
        end
    end

    assign changed = |(new_row ^ center);

endmodule

// ===== rtl/life_generation_step.sv =====
// Top level of the life generation step block: board memory, sequencer, ports.
// Depends on lgs_pkg and lgs_row_update.
`timescale 1ns / 1ps

// Game of Life (B3/S23) engine on a board of up to 64 x 64 one-bit cells.
// Input words (s_axis) carry an action in tuser: write a cell, read a cell,
// or advance one generation. Every input word yields exactly one result word
// on m_axis: addressed cell (reads only), changed flag of the latest
// generation, and a saturating generation count.
// The board is a memory of one word per row, read one row per cycle through
// a registered read port; a generation streams the rows in order and
// keeps the row above and the current row in registers. Cell reads and
// writes pass through read, modify or select, and result steps. One word
// is in work at a time.
// The result sits in an output register; a new word is accepted while it
// waits, but the next result is held back until m_axis_tready frees it.
// Reset clears all row valid bits (every cell dead), the counter, the flag,
// and sets both grid dimensions to 64. Configuration words on cfg_* are
// always taken and must arrive only while the block is idle.
module life_generation_step
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] row, [11:6] col, [12] cell_in, [15:13] zero
    input  logic [lgs_pkg::IN_W-1:0]            s_axis_tdata,
    // [1:0] action
    input  logic [lgs_pkg::ACT_W-1:0]           s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] cell_out, [1] board_changed, [17:2] generation, [23:18] zero
    output logic [lgs_pkg::OUT_W-1:0]           m_axis_tdata,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgs_pkg::DIM_W-1:0]           cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CELL = 3'd1;
    localparam logic [2:0] ST_G0   = 3'd2;
    localparam logic [2:0] ST_GROW = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [lgs_pkg::DIM_W-1:0]         rows_reg, cols_reg;
    logic [lgs_pkg::ACT_W-1:0]         act_reg, act_next;
    logic [lgs_pkg::ROW_AW-1:0]        row_reg, row_next;
    logic [lgs_pkg::COL_AW-1:0]        col_reg, col_next;
    logic                              cell_in_reg, cell_in_next;
    logic                              inside_reg, inside_next;
    logic [lgs_pkg::CNT_W-1:0]         row_cnt_reg, row_cnt_next;
    lgs_pkg::row_t                     prev_row_reg, prev_row_next;
    lgs_pkg::row_t                     cur_row_reg, cur_row_next;
    logic                              any_reg, any_next;
    logic                              changed_reg, changed_next;
    logic [lgs_pkg::GEN_W-1:0]         gen_reg, gen_next;
    logic                              cell_out_reg, cell_out_next;
    logic                              m_valid_reg, m_valid_next;
    logic [lgs_pkg::OUT_W-1:0]         m_data_reg, m_data_next;
    logic [lgs_pkg::MAX_ROWS-1:0]      row_valid_reg;

    // board memory, one row per word; rows never written read as dead
    lgs_pkg::row_t                     board_mem [lgs_pkg::MAX_ROWS];
    lgs_pkg::row_t                     rd_data_reg;
    logic                              rd_valid_reg;
    logic [lgs_pkg::ROW_AW-1:0]        mem_raddr;
    logic                              mem_we;
    logic [lgs_pkg::ROW_AW-1:0]        mem_waddr;
    lgs_pkg::row_t                     mem_wdata;
    lgs_pkg::row_t                     rd_row;

    logic [lgs_pkg::CNT_W-1:0]         nr;
    logic [lgs_pkg::CCNT_W-1:0]        nc;
    lgs_pkg::row_t                     col_mask;
    lgs_pkg::row_t                     below_row;
    lgs_pkg::row_t                     upd_row;
    logic                              upd_changed;
    logic [lgs_pkg::CNT_W-1:0]         row_cnt_inc;

    logic                              in_fire;
    logic                              slot_free;
    logic [lgs_pkg::FIELD_W-1:0]       in_row, in_col;

    assign in_row = s_axis_tdata[5:0];
    assign in_col = s_axis_tdata[11:6];

    // clamped grid dimensions
    always_comb
    begin
        if (rows_reg == '0)
            nr = lgs_pkg::CNT_W'(1);
        else if (int'(rows_reg) > lgs_pkg::MAX_ROWS)
            nr = lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS);
        else
            nr = lgs_pkg::CNT_W'(rows_reg);
        if (cols_reg == '0)
            nc = lgs_pkg::CCNT_W'(1);
        else if (int'(cols_reg) > lgs_pkg::MAX_COLS)
            nc = lgs_pkg::CCNT_W'(lgs_pkg::MAX_COLS);
        else
            nc = lgs_pkg::CCNT_W'(cols_reg);
    end

    always_comb
    begin
        for (int c = 0; c < lgs_pkg::MAX_COLS; c++)
            col_mask[c] = (c < int'(nc));
    end

    assign rd_row      = rd_valid_reg ? rd_data_reg : '0;
    assign row_cnt_inc = row_cnt_reg + lgs_pkg::CNT_W'(1);
    // row below the current one, dead past the last row in use
    assign below_row   = (row_cnt_inc < nr) ? rd_row : '0;

    lgs_row_update u_row_update
    (
        .above    (prev_row_reg),
        .center   (cur_row_reg),
        .below    (below_row),
        .col_mask (col_mask),
        .new_row  (upd_row),
        .changed  (upd_changed)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cell_in_next  = cell_in_reg;
        inside_next   = inside_reg;
        row_cnt_next  = row_cnt_reg;
        prev_row_next = prev_row_reg;
        cur_row_next  = cur_row_reg;
        any_next      = any_reg;
        changed_next  = changed_reg;
        gen_next      = gen_reg;
        cell_out_next = cell_out_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_raddr     = row_reg;
        mem_we        = 1'b0;
        mem_waddr     = row_reg;
        mem_wdata     = rd_row;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = lgs_pkg::ROW_AW'(in_row);
                if (in_fire)
                begin
                    act_next      = s_axis_tuser;
                    row_next      = lgs_pkg::ROW_AW'(in_row);
                    col_next      = lgs_pkg::COL_AW'(in_col);
                    cell_in_next  = s_axis_tdata[12];
                    inside_next   = (lgs_pkg::CNT_W'(in_row) < nr)
                                 && (lgs_pkg::CCNT_W'(in_col) < nc);
                    cell_out_next = 1'b0;
                    if (s_axis_tuser == lgs_pkg::ACT_STEP)
                    begin
                        mem_raddr     = '0;
                        row_cnt_next  = '0;
                        prev_row_next = '0;
                        any_next      = 1'b0;
                        state_next    = ST_G0;
                    end
                    else if (s_axis_tuser == lgs_pkg::ACT_WRITE
                          || s_axis_tuser == lgs_pkg::ACT_READ)
                        state_next = ST_CELL;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_CELL:
            begin
                if (act_reg == lgs_pkg::ACT_WRITE)
                begin
                    mem_wdata          = rd_row;
                    mem_wdata[col_reg] = cell_in_reg;
                    mem_we             = inside_reg;
                end
                else
                    cell_out_next = inside_reg && rd_row[col_reg];
                state_next = ST_DONE;
            end
            ST_G0:
            begin
                cur_row_next = rd_row;
                mem_raddr    = lgs_pkg::ROW_AW'(1);
                state_next   = ST_GROW;
            end
            ST_GROW:
            begin
                mem_we        = 1'b1;
                mem_waddr     = row_cnt_reg[lgs_pkg::ROW_AW-1:0];
                mem_wdata     = upd_row;
                mem_raddr     = row_cnt_reg[lgs_pkg::ROW_AW-1:0] + lgs_pkg::ROW_AW'(2);
                prev_row_next = cur_row_reg;
                cur_row_next  = below_row;
                any_next      = any_reg || upd_changed;
                row_cnt_next  = row_cnt_inc;
                if (row_cnt_inc == nr)
                begin
                    changed_next = any_reg || upd_changed;
                    if (gen_reg != lgs_pkg::GEN_MAX)
                        gen_next = gen_reg + lgs_pkg::GEN_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[0]   = cell_out_reg;
                    m_data_next[1]   = changed_reg;
                    m_data_next[17:2] = gen_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= lgs_pkg::DIM_W'(lgs_pkg::MAX_ROWS);
            cols_reg      <= lgs_pkg::DIM_W'(lgs_pkg::MAX_COLS);
            changed_reg   <= 1'b0;
            gen_reg       <= '0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            row_cnt_reg   <= '0;
            act_reg       <= lgs_pkg::ACT_WRITE;
        end
        else
        begin
            state_reg    <= state_next;
            changed_reg  <= changed_next;
            gen_reg      <= gen_next;
            m_valid_reg  <= m_valid_next;
            row_cnt_reg  <= row_cnt_next;
            act_reg      <= act_next;
            rd_valid_reg <= row_valid_reg[mem_raddr];
            if (mem_we)
                row_valid_reg[mem_waddr] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == lgs_pkg::CFG_ROWS)
                    rows_reg <= cfg_data;
                else if (cfg_index == lgs_pkg::CFG_COLS)
                    cols_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        cell_in_reg  <= cell_in_next;
        inside_reg   <= inside_next;
        prev_row_reg <= prev_row_next;
        cur_row_reg  <= cur_row_next;
        any_reg      <= any_next;
        cell_out_reg <= cell_out_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            board_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= board_mem[mem_raddr];
    end

    // board is only written while handling a cell write or sweeping a generation
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CELL || state_reg == ST_GROW))
        else $error("board write outside cell or sweep state");

    // sweep never runs past the last row in use
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GROW) |-> (row_cnt_reg < nr))
        else $error("generation sweep past last row");

    // generation count never goes backwards
    a_gen_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (gen_reg >= $past(gen_reg)))
        else $error("generation count decreased");

    // a finished result waits while the output register is still held
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_DONE && $stable(m_data_reg)))
        else $error("result overwrote a stalled output word");

endmodule
